[rtl/rcfe_pkg.sv]
package rcfe_pkg;

    // Command codes carried by the input word.
    localparam logic CMD_PRESS  = 1'b0;
    localparam logic CMD_REPEAT = 1'b1;

    // Configuration register indexes.
    localparam logic [1:0] CFG_SERIAL      = 2'd0;
    localparam logic [1:0] CFG_KEY         = 2'd1;
    localparam logic [1:0] CFG_COUNTER     = 2'd2;

    localparam int SERIAL_W   = 28;
    localparam int KEY_W      = 64;
    localparam int COUNTER_W  = 16;
    localparam int HOP_W      = 32;
    localparam int BUTTON_W   = 4;
    localparam int DISC_W     = 12;
    localparam int BYTE_W     = 8;

    localparam int FRAME_BYTES = 9;
    localparam int FRAME_BITS  = FRAME_BYTES * BYTE_W;

    // KeeLoq nonlinear function, indexed by five state bits.
    localparam logic [31:0] NLF_TABLE = 32'h3A5C_742E;

    localparam logic [BYTE_W-1:0] STATUS_NEW    = 8'h00;
    localparam logic [BYTE_W-1:0] STATUS_REPEAT = 8'h40;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CIPHER,
        ST_SEND
    } t_back_state;

    // One queued command word.
    typedef struct packed {
        logic                cmd;
        logic [BUTTON_W-1:0] button;
    } t_cmd_word;

    // Configuration as seen by the back end.
    typedef struct packed {
        logic [SERIAL_W-1:0]  serial;
        logic [KEY_W-1:0]     key;
        logic                 cnt_load_en;
        logic [COUNTER_W-1:0] cnt_load;
    } t_cfg;

    // Packs hop, serial and button bit-reversed, then the status byte.
    function automatic logic [FRAME_BITS-1:0] build_frame(
        input logic [HOP_W-1:0]    hop,
        input logic [SERIAL_W-1:0] ser,
        input logic [BUTTON_W-1:0] btn,
        input logic [BYTE_W-1:0]   status
    );
        logic [HOP_W-1:0]    hop_tx;
        logic [SERIAL_W-1:0] ser_tx;
        logic [BUTTON_W-1:0] btn_tx;
        for (int k = 0; k < HOP_W; k++) begin
            hop_tx[k] = hop[HOP_W-1-k];
        end
        for (int k = 0; k < SERIAL_W; k++) begin
            ser_tx[k] = ser[SERIAL_W-1-k];
        end
        for (int k = 0; k < BUTTON_W; k++) begin
            btn_tx[k] = btn[BUTTON_W-1-k];
        end
        return {hop_tx, ser_tx, btn_tx, status};
    endfunction

endpackage

[rtl/rolling_code_frame_encoder_top.sv]
// A repeat word's first frame byte is loaded into the output register as the back end takes
// it from the queue; a new press first runs the KeeLoq round unit, one round per cycle, and
// the frame is loaded from its result. The back end takes the next word from the queue only
// after the last of the nine output words has been taken.
// Reset: synchronous, active low; it clears the queue, the sequencer, configuration, the counter
// and the stored hop word and button. No clearing pass is needed.
module rolling_code_frame_encoder_top #(
    parameter int KEELOQ_ROUNDS = 528
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input channel: one word per button event.
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_cmd,
    input  logic [3:0]  i_button,
    // Output channel: nine frame bytes per input word.
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_frame_byte,
    output logic        o_last,
    // Configuration write channel.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);
    import rcfe_pkg::*;

    // Configuration registers. The counter load value goes straight into the
    // sync counter held by the back end, so it needs no register of its own here.
    logic [SERIAL_W-1:0] r_serial;
    logic [KEY_W-1:0]    r_key;
    logic                cfg_we;
    t_cfg                cfg;
    t_cmd_word           in_word;
    t_cmd_word           head;
    logic                head_valid;
    logic                pop;

    // Writes are always taken; an index past the list is dropped.
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_serial <= '0;
            r_key    <= '0;
        end else if (cfg_we) begin
            case (i_cfg_index)
                CFG_SERIAL:  r_serial <= i_cfg_data[SERIAL_W-1:0];
                CFG_KEY:     r_key    <= i_cfg_data;
                default:     ;
            endcase
        end
    end

    assign cfg.serial      = r_serial;
    assign cfg.key         = r_key;
    assign cfg.cnt_load_en = cfg_we && (i_cfg_index == CFG_COUNTER);
    assign cfg.cnt_load    = i_cfg_data[COUNTER_W-1:0];

    assign in_word.cmd    = i_cmd;
    assign in_word.button = i_button;

    // The front end queues up to two incoming words so the input keeps flowing while the back
    // end is busy encrypting or sending a frame; it stalls the input when both entries are full.
    rcfe_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_word       (in_word),
        .o_head_valid (head_valid),
        .o_head       (head),
        .i_pop        (pop)
    );

    // The back end runs the cipher for new presses, keeps the rolling state and
    // sends the nine-byte frame from its output register.
    rcfe_back #(
        .KEELOQ_ROUNDS(KEELOQ_ROUNDS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_frame_byte (o_frame_byte),
        .o_last       (o_last)
    );

endmodule

[rtl/rcfe_front.sv]
module rcfe_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  rcfe_pkg::t_cmd_word i_word,
    output logic              o_head_valid,
    output rcfe_pkg::t_cmd_word o_head,
    input  logic              i_pop
);
    import rcfe_pkg::*;

    // Two-entry command queue between the input port and the back end.
    t_cmd_word  r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       push;
    logic       pop;

    assign o_stall      = (r_count == 2'd2);
    assign push         = i_valid && !o_stall;
    assign pop          = i_pop && (r_count != 2'd0);
    assign o_head_valid = (r_count != 2'd0);
    assign o_head       = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

[rtl/rcfe_cipher.sv]
module rcfe_cipher #(
    parameter int KEELOQ_ROUNDS = 528
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [rcfe_pkg::HOP_W-1:0]     i_plain,
    input  logic [rcfe_pkg::KEY_W-1:0]     i_key,
    output logic                           o_done,
    output logic [rcfe_pkg::HOP_W-1:0]     o_hop
);
    import rcfe_pkg::*;

    localparam int RW = $clog2(KEELOQ_ROUNDS);

    logic [HOP_W-1:0] r_x;
    logic [KEY_W-1:0] r_key;
    logic [RW-1:0]    r_round;
    logic             r_busy;
    logic             r_done;
    logic [4:0]       sel;
    logic             fb;

    // One round per cycle; the key register rotates so its bit 0 is key bit (round mod 64).
    assign sel = {r_x[31], r_x[26], r_x[20], r_x[9], r_x[1]};
    assign fb  = r_x[0] ^ r_x[16] ^ r_key[0] ^ NLF_TABLE[sel];

    assign o_done = r_done;
    assign o_hop  = r_x;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= i_plain;
            r_key <= i_key;
        end else if (r_busy) begin
            r_x   <= {fb, r_x[HOP_W-1:1]};
            r_key <= {r_key[0], r_key[KEY_W-1:1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_round <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_round <= '0;
            end else if (r_busy) begin
                r_round <= r_round + 1'b1;
                if (r_round == RW'(KEELOQ_ROUNDS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

[rtl/rcfe_back.sv]
module rcfe_back #(
    parameter int KEELOQ_ROUNDS = 528
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rcfe_pkg::t_cfg                i_cfg,
    input  logic                          i_head_valid,
    input  rcfe_pkg::t_cmd_word           i_head,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [rcfe_pkg::BYTE_W-1:0]   o_frame_byte,
    output logic                          o_last
);
    import rcfe_pkg::*;

    localparam logic [3:0] LAST_IDX = 4'(FRAME_BYTES - 1);

    t_back_state           r_state, n_state;
    logic [FRAME_BITS-1:0] r_frame, n_frame;
    logic [3:0]            r_cnt, n_cnt;
    logic                  r_out_valid, n_out_valid;
    logic [HOP_W-1:0]      r_held_hop, n_held_hop;
    logic [BUTTON_W-1:0]   r_held_button, n_held_button;
    logic [COUNTER_W-1:0]  r_counter, n_counter;
    logic                  start;
    logic                  done;
    logic [HOP_W-1:0]      hop;
    logic [HOP_W-1:0]      plain;

    assign plain = {i_head.button, i_cfg.serial[DISC_W-1:0], r_counter};

    rcfe_cipher #(
        .KEELOQ_ROUNDS(KEELOQ_ROUNDS)
    ) u_cipher (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_plain (plain),
        .i_key   (i_cfg.key),
        .o_done  (done),
        .o_hop   (hop)
    );

    assign o_valid      = r_out_valid;
    assign o_frame_byte = r_frame[FRAME_BITS-1 -: BYTE_W];
    assign o_last       = (r_cnt == LAST_IDX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_cnt         <= '0;
            r_out_valid   <= 1'b0;
            r_held_hop    <= '0;
            r_held_button <= '0;
            r_counter     <= '0;
        end else begin
            r_state       <= n_state;
            r_cnt         <= n_cnt;
            r_out_valid   <= n_out_valid;
            r_held_hop    <= n_held_hop;
            r_held_button <= n_held_button;
            r_counter     <= n_counter;
        end
    end

    always_ff @(posedge i_clk) begin
        r_frame <= n_frame;
    end

    always_comb begin
        n_state       = r_state;
        n_frame       = r_frame;
        n_cnt         = r_cnt;
        n_out_valid   = r_out_valid;
        n_held_hop    = r_held_hop;
        n_held_button = r_held_button;
        n_counter     = r_counter;
        o_pop         = 1'b0;
        start         = 1'b0;
        if (i_cfg.cnt_load_en) begin
            n_counter = i_cfg.cnt_load;
        end
        case (r_state)
            ST_IDLE: begin
                if (i_head_valid) begin
                    o_pop = 1'b1;
                    if (i_head.cmd == CMD_PRESS) begin
                        start         = 1'b1;
                        n_held_button = i_head.button;
                        n_state       = ST_CIPHER;
                    end else begin
                        n_frame     = build_frame(r_held_hop, i_cfg.serial,
                                                  r_held_button, STATUS_REPEAT);
                        n_cnt       = '0;
                        n_out_valid = 1'b1;
                        n_state     = ST_SEND;
                    end
                end
            end
            ST_CIPHER: begin
                if (done) begin
                    n_held_hop  = hop;
                    n_counter   = r_counter + 1'b1;
                    n_frame     = build_frame(hop, i_cfg.serial, r_held_button, STATUS_NEW);
                    n_cnt       = '0;
                    n_out_valid = 1'b1;
                    n_state     = ST_SEND;
                end
            end
            ST_SEND: begin
                if (!i_stall) begin
                    if (r_cnt == LAST_IDX) begin
                        n_out_valid = 1'b0;
                        n_state     = ST_IDLE;
                    end else begin
                        n_frame = {r_frame[FRAME_BITS-BYTE_W-1:0], {BYTE_W{1'b0}}};
                        n_cnt   = r_cnt + 1'b1;
                    end
                end
            end
            default: begin
                n_state     = ST_IDLE;
                n_out_valid = 1'b0;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_valid_only_in_send: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_state == ST_SEND))
        else $error("output word valid outside the send state");

    a_done_starts_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done |=> (r_out_valid && (r_cnt == '0)))
        else $error("cipher completion did not start a frame at byte zero");

    a_last_ends_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_stall && (r_cnt == LAST_IDX)) |=> !r_out_valid)
        else $error("output still valid after the last byte was taken");
`endif

endmodule
